// ===== hdl/lkvc_pkg.sv =====
package lkvc_pkg;

   localparam int DEFAULT_ENTRIES = 16;
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;
   localparam logic [VAL_W-1:0] MISS_VALUE = '1;

   localparam logic ACTION_GET = 1'b0;
   localparam logic ACTION_SET = 1'b1;

   typedef struct packed {
      logic             action;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic             hit;
      logic [VAL_W-1:0] read_value;
   } rsp_type;

endpackage

// ===== hdl/lru_key_value_cache.sv =====
// Fully associative key/value store with LRU replacement. An item is taken when start is
// high and busy is low; busy then stays high until the item is finished. Every item first
// scans all ENTRIES slots of the entry memory, one slot per cycle through its single read
// port. A get that misses finishes once the scan is done and gives its result then. A get
// that hits, and every set, then makes a second pass over the memory to rewrite the recency
// ranks, one slot per cycle. A get's result appears on rsp_payload for exactly one cycle
// with rsp_strobe high; there is no back-pressure, the receiver must take it. A set gives
// no result. The capacity register is written through csr_valid/csr_data and is only
// taken while the store is empty; zero acts as one and values above ENTRIES act as
// ENTRIES. Valid bits are cleared by reset, so no clearing pass is needed.
module lru_key_value_cache #(
   parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lkvc_pkg::req_type             req_payload,
   output logic                          rsp_strobe,
   output lkvc_pkg::rsp_type             rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lkvc_pkg::CAP_W-1:0]    csr_data
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int CW     = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;
   localparam int KEY_W  = lkvc_pkg::KEY_W;
   localparam int VAL_W  = lkvc_pkg::VAL_W;
   localparam int WORD_W = KEY_W + VAL_W + RANK_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_SDRAIN = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_UPD    = 3'd4;
   localparam logic [2:0] S_UDRAIN = 3'd5;

   logic [2:0]               state_ff;
   logic [IDX_W-1:0]         idx_ff;
   lkvc_pkg::req_type        req_ff;
   logic [ENTRIES-1:0]       valid_ff;
   logic [OCC_W-1:0]         occ_ff;
   logic [lkvc_pkg::CAP_W-1:0] cap_ff;

   // entry memory: {key, value, rank}
   logic [WORD_W-1:0]        mem [ENTRIES];
   logic [WORD_W-1:0]        rd_ff;
   logic                     chk_valid_ff;
   logic                     chk_upd_ff;
   logic [IDX_W-1:0]         chk_idx_ff;

   logic                     hit_ff;
   logic [IDX_W-1:0]         hit_idx_ff;
   logic [RANK_W-1:0]        hit_rank_ff;
   logic [VAL_W-1:0]         hit_val_ff;
   logic [IDX_W-1:0]         lru_idx_ff;
   logic                     free_found_ff;
   logic [IDX_W-1:0]         free_idx_ff;

   // rewrite pass controls
   logic [IDX_W-1:0]         tgt_ff;
   logic [RANK_W-1:0]        thr_ff;
   logic                     all_ff;
   logic [VAL_W-1:0]         tgt_val_ff;

   logic                     rsp_strobe_ff;
   lkvc_pkg::rsp_type        rsp_ff;

   logic [KEY_W-1:0]         rd_key;
   logic [VAL_W-1:0]         rd_val;
   logic [RANK_W-1:0]        rd_rank;
   logic                     rd_entry_valid;
   logic                     mem_we;
   logic [WORD_W-1:0]        mem_wd;
   logic [CW-1:0]            cap_x;
   logic [CW-1:0]            eff_cap;
   logic                     full;
   logic [IDX_W-1:0]         ins_slot;
   logic [RANK_W-1:0]        lru_rank_match;

   assign rd_key         = rd_ff[WORD_W-1 -: KEY_W];
   assign rd_val         = rd_ff[RANK_W +: VAL_W];
   assign rd_rank        = rd_ff[RANK_W-1:0];
   assign rd_entry_valid = valid_ff[chk_idx_ff];
   assign lru_rank_match = RANK_W'(occ_ff - OCC_W'(1));

   always_comb begin
      cap_x = CW'(cap_ff);
      if (cap_x == '0) begin
         eff_cap = CW'(1);
      end else if (cap_x > CW'(ENTRIES)) begin
         eff_cap = CW'(ENTRIES);
      end else begin
         eff_cap = cap_x;
      end
   end

   assign full = CW'(occ_ff) >= eff_cap;

   // lowest invalid slot once the LRU entry has been dropped
   assign ins_slot = (full && (!free_found_ff || lru_idx_ff < free_idx_ff)) ?
                     lru_idx_ff : free_idx_ff;

   always_comb begin
      mem_we = 1'b0;
      mem_wd = rd_ff;
      if (chk_valid_ff && chk_upd_ff) begin
         if (chk_idx_ff == tgt_ff) begin
            mem_we = 1'b1;
            mem_wd = {req_ff.key, tgt_val_ff, RANK_W'(0)};
         end else if (rd_entry_valid && (all_ff || rd_rank < thr_ff)) begin
            mem_we = 1'b1;
            mem_wd = {rd_key, rd_val, rd_rank + RANK_W'(1)};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[chk_idx_ff] <= mem_wd;
      end
      rd_ff      <= mem[idx_ff];
      chk_idx_ff <= idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         valid_ff      <= '0;
         occ_ff        <= '0;
         cap_ff        <= lkvc_pkg::CAPACITY_RESET;
         chk_valid_ff  <= 1'b0;
         chk_upd_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         chk_valid_ff  <= (state_ff == S_SCAN) || (state_ff == S_UPD);
         chk_upd_ff    <= (state_ff == S_UPD);
         rsp_strobe_ff <= 1'b0;

         if (csr_valid && occ_ff == '0) begin
            cap_ff <= csr_data;
         end

         // scan: collect match, LRU and first free slot
         if (chk_valid_ff && !chk_upd_ff) begin
            if (rd_entry_valid && rd_key == req_ff.key) begin
               hit_ff      <= 1'b1;
               hit_idx_ff  <= chk_idx_ff;
               hit_rank_ff <= rd_rank;
               hit_val_ff  <= rd_val;
            end
            if (rd_entry_valid && rd_rank == lru_rank_match) begin
               lru_idx_ff <= chk_idx_ff;
            end
            if (!rd_entry_valid && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= chk_idx_ff;
            end
         end

         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff        <= req_payload;
                  idx_ff        <= '0;
                  hit_ff        <= 1'b0;
                  free_found_ff <= 1'b0;
                  state_ff      <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (idx_ff == LAST_IDX) begin
                  idx_ff   <= '0;
                  state_ff <= S_SDRAIN;
               end else begin
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            S_SDRAIN: begin
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               idx_ff <= '0;
               if (req_ff.action == lkvc_pkg::ACTION_GET) begin
                  rsp_strobe_ff      <= 1'b1;
                  rsp_ff.hit         <= hit_ff;
                  rsp_ff.read_value  <= hit_ff ? hit_val_ff : lkvc_pkg::MISS_VALUE;
                  tgt_ff             <= hit_idx_ff;
                  thr_ff             <= hit_rank_ff;
                  all_ff             <= 1'b0;
                  tgt_val_ff         <= hit_val_ff;
                  state_ff           <= hit_ff ? S_UPD : S_IDLE;
               end else if (hit_ff) begin
                  tgt_ff     <= hit_idx_ff;
                  thr_ff     <= hit_rank_ff;
                  all_ff     <= 1'b0;
                  tgt_val_ff <= req_ff.value;
                  state_ff   <= S_UPD;
               end else begin
                  // insert; with a full store the LRU entry goes first
                  if (full) begin
                     valid_ff <= (valid_ff & ~(ENTRIES'(1) << lru_idx_ff)) |
                                 (ENTRIES'(1) << ins_slot);
                  end else begin
                     valid_ff[ins_slot] <= 1'b1;
                     occ_ff <= occ_ff + OCC_W'(1);
                  end
                  tgt_ff     <= ins_slot;
                  thr_ff     <= '0;
                  all_ff     <= 1'b1;
                  tgt_val_ff <= req_ff.value;
                  state_ff   <= S_UPD;
               end
            end
            S_UPD: begin
               if (idx_ff == LAST_IDX) begin
                  idx_ff   <= '0;
                  state_ff <= S_UDRAIN;
               end else begin
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            S_UDRAIN: begin
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule
